[rtl/dspe_pkg.sv]
package dspe_pkg;

  // Distance word: unsigned Q16.8, all ones marks an unreached node
  localparam int unsigned DIST_W   = 24;
  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_INF - 1'b1;

  // Extra rounds allowed beyond the node count before the search gives up
  localparam int unsigned ROUND_SLACK = 2;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_NODES_DEF   = 32;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // Request codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Register map (word index taken from paddr[2])
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

endpackage

[rtl/dense_shortest_path_engine.sv]
// Single-source shortest paths from node 0 over a dense adjacency matrix held in an
// on-chip RAM of MAX_NODES*MAX_NODES entries (connected flag plus Q8.8 weight). A load
// request writes one matrix entry. A run request searches over the first node_count
// nodes and then returns one result per node, in node order, with last set on the final
// one. Each search round streams one row of the matrix and the node-state RAM at one
// entry per cycle, relaxing and picking the next node in the same pass; the single read
// port of the node-state RAM sets this pace. Node state is invalidated at the start of
// a run, so there is no clearing pass. Matrix entries that were never loaded read as
// undefined, so load every entry a run can reach. The user must write node_count
// through the register port only while the block is idle; the block does not enforce it.
module dense_shortest_path_engine #(
  parameter int unsigned MAX_NODES   = dspe_pkg::MAX_NODES_DEF,
  parameter int unsigned WEIGHT_BITS = dspe_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dspe_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [dspe_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [dspe_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [$clog2(MAX_NODES)-1:0]         from_node_i,
  input  logic [$clog2(MAX_NODES)-1:0]         to_node_i,
  input  logic                                 connected_i,
  input  logic [WEIGHT_BITS-1:0]               edge_weight_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [$clog2(MAX_NODES)-1:0]         node_index_o,
  output logic [dspe_pkg::DIST_W-1:0]          distance_o,
  output logic [$clog2(MAX_NODES)-1:0]         predecessor_o,
  output logic                                 reachable_o,
  output logic                                 last_o
);
  import dspe_pkg::*;

  localparam int unsigned IDX_W      = $clog2(MAX_NODES);
  localparam int unsigned CNT_W      = $clog2(MAX_NODES + 1);
  localparam int unsigned RND_W      = $clog2(MAX_NODES + ROUND_SLACK + 2);
  localparam int unsigned EDGE_W     = WEIGHT_BITS + 1;
  localparam int unsigned EDGE_DEPTH = 2 ** (2 * IDX_W);
  localparam int unsigned NODE_W     = IDX_W + DIST_W;
  localparam int unsigned SUM_W      = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_RELAX   = 5'b00010,
    S_ROUND   = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT_LD = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      node_count_q;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic [DIST_W-1:0]     dist_cur_q, dist_cur_d;
  logic [CNT_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  p_vld_q, p_vld_d;
  logic [IDX_W-1:0]      p_idx_q, p_idx_d;
  logic [DIST_W-1:0]     best_q, best_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [RND_W-1:0]      rounds_q, rounds_d;
  logic [MAX_NODES-1:0]  visited_q, visited_d;
  logic [MAX_NODES-1:0]  node_vld_q, node_vld_d;
  logic [IDX_W-1:0]      emit_idx_q, emit_idx_d;

  logic                  out_valid_q, out_valid_d;
  logic [IDX_W-1:0]      out_idx_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic [IDX_W-1:0]      out_pred_q;
  logic                  out_last_q;
  logic                  out_load;

  // memories
  logic [EDGE_W-1:0]     edge_mem [EDGE_DEPTH];
  logic [NODE_W-1:0]     node_mem [MAX_NODES];
  logic [EDGE_W-1:0]     edge_rd_q;
  logic [NODE_W-1:0]     node_rd_q;

  logic                  in_acc;
  logic                  edge_we;
  logic [2*IDX_W-1:0]    edge_waddr;
  logic                  rd_en;
  logic [IDX_W-1:0]      node_raddr;
  logic                  node_we;
  logic [NODE_W-1:0]     node_wdata;

  logic [CNT_W-1:0]      n_run;
  logic [DIST_W-1:0]     dist_v;
  logic [SUM_W-1:0]      sum;
  logic [DIST_W-1:0]     cand;
  logic                  upd;
  logic [DIST_W-1:0]     new_dist;
  logic                  found;
  logic [IDX_W-1:0]      sel_idx;
  logic [MAX_NODES-1:0]  visited_nx;
  logic [RND_W-1:0]      rounds_nx;
  logic                  all_done;
  logic                  search_done;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DATA_W'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(MAX_NODES);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT)) begin
      node_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // clamp the node count into 1..MAX_NODES
  always_comb begin
    n_run = node_count_q;
    if (node_count_q == '0) n_run = CNT_W'(1);
    else if (node_count_q > CNT_W'(MAX_NODES)) n_run = CNT_W'(MAX_NODES);
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // edge loads; out-of-range indices drop the request
  assign edge_we    = in_acc && (op_i == OP_LOAD) &&
                      (CNT_W'(from_node_i) < CNT_W'(MAX_NODES)) &&
                      (CNT_W'(to_node_i) < CNT_W'(MAX_NODES));
  assign edge_waddr = {from_node_i, to_node_i};

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= {connected_i, edge_weight_i};
    end
    if (rd_en) begin
      edge_rd_q <= edge_mem[{cur_q, rd_idx_q[IDX_W-1:0]}];
    end
  end

  // node state memory: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[p_idx_q] <= node_wdata;
    end
    if (rd_en) begin
      node_rd_q <= node_mem[node_raddr];
    end
  end

  assign rd_en      = ((state_q == S_RELAX) && (rd_idx_q < n_q)) || (state_q == S_EMIT_RD);
  assign node_raddr = (state_q == S_RELAX) ? rd_idx_q[IDX_W-1:0] : emit_idx_q;

  // distance as returned, invalid entries read as their reset value
  always_comb begin
    if (node_vld_q[p_idx_q]) begin
      dist_v = node_rd_q[DIST_W-1:0];
    end else begin
      dist_v = (p_idx_q == '0) ? '0 : DIST_INF;
    end
  end

  // saturating relaxation candidate
  assign sum      = SUM_W'(dist_cur_q) + SUM_W'(edge_rd_q[WEIGHT_BITS-1:0]);
  assign cand     = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  assign upd      = p_vld_q && edge_rd_q[WEIGHT_BITS] && !visited_q[p_idx_q] &&
                    (dist_v > cand);
  assign new_dist = upd ? cand : dist_v;

  assign node_we    = (state_q == S_RELAX) && upd;
  assign node_wdata = {cur_q, cand};

  // end-of-round selection and termination
  assign found     = (best_q != DIST_INF);
  assign sel_idx   = found ? best_idx_q : '0;
  assign rounds_nx = rounds_q + 1'b1;

  always_comb begin
    visited_nx = visited_q;
    visited_nx[sel_idx] = 1'b1;
    all_done = 1'b1;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (!visited_nx[i] && (CNT_W'(i) < n_q)) all_done = 1'b0;
    end
  end

  assign search_done = all_done ||
                       (rounds_nx > (RND_W'(n_q) + RND_W'(ROUND_SLACK)));

  assign out_load = (state_q == S_EMIT_LD) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cur_d       = cur_q;
    dist_cur_d  = dist_cur_q;
    rd_idx_d    = rd_idx_q;
    p_vld_d     = 1'b0;
    p_idx_d     = p_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    rounds_d    = rounds_q;
    visited_d   = visited_q;
    node_vld_d  = node_vld_q;
    emit_idx_d  = emit_idx_q;
    out_valid_d = out_valid_q;

    // drop the held result once taken
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && (op_i == OP_RUN)) begin
          n_d        = n_run;
          cur_d      = '0;
          dist_cur_d = '0;
          rd_idx_d   = '0;
          best_d     = DIST_INF;
          best_idx_d = '0;
          rounds_d   = '0;
          visited_d  = '0;
          node_vld_d = '0;
          state_d    = S_RELAX;
        end
      end
      S_RELAX: begin
        // issue one read per cycle
        if (rd_idx_q < n_q) begin
          p_vld_d  = 1'b1;
          p_idx_d  = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + 1'b1;
        end
        // retire the returned node: write back and track the minimum
        if (p_vld_q) begin
          if (upd) node_vld_d[p_idx_q] = 1'b1;
          if (!visited_q[p_idx_q] && (new_dist < best_q)) begin
            best_d     = new_dist;
            best_idx_d = p_idx_q;
          end
          if (CNT_W'(p_idx_q) == n_q - 1'b1) state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        visited_d  = visited_nx;
        rounds_d   = rounds_nx;
        cur_d      = sel_idx;
        dist_cur_d = found ? best_q : '0;
        rd_idx_d   = '0;
        best_d     = DIST_INF;
        best_idx_d = '0;
        emit_idx_d = '0;
        state_d    = search_done ? S_EMIT_RD : S_RELAX;
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (CNT_W'(emit_idx_q) == n_q - 1'b1) begin
            state_d = S_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= CNT_W'(1);
      cur_q       <= '0;
      dist_cur_q  <= '0;
      rd_idx_q    <= '0;
      p_vld_q     <= 1'b0;
      p_idx_q     <= '0;
      best_q      <= DIST_INF;
      best_idx_q  <= '0;
      rounds_q    <= '0;
      visited_q   <= '0;
      node_vld_q  <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      cur_q       <= cur_d;
      dist_cur_q  <= dist_cur_d;
      rd_idx_q    <= rd_idx_d;
      p_vld_q     <= p_vld_d;
      p_idx_q     <= p_idx_d;
      best_q      <= best_d;
      best_idx_q  <= best_idx_d;
      rounds_q    <= rounds_d;
      visited_q   <= visited_d;
      node_vld_q  <= node_vld_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= emit_idx_q;
      out_last_q <= (CNT_W'(emit_idx_q) == n_q - 1'b1);
      if (node_vld_q[emit_idx_q]) begin
        out_dist_q <= node_rd_q[DIST_W-1:0];
        out_pred_q <= node_rd_q[NODE_W-1:DIST_W];
      end else begin
        out_dist_q <= (emit_idx_q == '0) ? '0 : DIST_INF;
        out_pred_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign node_index_o  = out_idx_q;
  assign distance_o    = out_dist_q;
  assign predecessor_o = out_pred_q;
  assign reachable_o   = (out_dist_q != DIST_INF);
  assign last_o        = out_last_q;

endmodule
